// ===== rtl/rhh_pkg.sv =====
// Shared types and constants for the Robin Hood hash table.
package rhh_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DIST_W = 7;
    localparam int HASH_W = 48;
    localparam int ITEM_W = 32;

    localparam logic [HASH_W-1:0] HASH_MASK    = 48'hFFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0]  MAX_FILL_RST = 7'd38;

    typedef enum logic [1:0] {
        FN_GET    = 2'd0,
        FN_SET    = 2'd1,
        FN_REMOVE = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_INSERT,
        ST_SHIFT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [HASH_W-1:0] hash;
        logic [ITEM_W-1:0] item;
    } t_slot;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_slot            wr_data;
        logic             clr_en;
        logic [IDX_W-1:0] clr_addr;
        logic             clr_all;
    } t_ram_cmd;

    typedef struct packed {
        logic  vld;
        t_slot slot;
    } t_ram_rd;

    typedef struct packed {
        logic empty;
        logic match;
        logic poorer;
        logic near_home;
    } t_cmp;

    typedef struct packed {
        logic              found;
        logic [ITEM_W-1:0] item_out;
        logic              status;
        logic [CNT_W-1:0]  entry_total;
    } t_result;

endpackage

// ===== rtl/rhh_intf.sv =====
// Handshake channel interfaces: request, response and config write.
interface rhh_req_if;
    import rhh_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [HASH_W-1:0] key_hash;
    logic [ITEM_W-1:0] item_value;
    modport source (output valid, func, key_hash, item_value, input ready);
    modport sink   (input valid, func, key_hash, item_value, output ready);
endinterface

interface rhh_rsp_if;
    import rhh_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ITEM_W-1:0] item_out;
    logic              status;
    logic [CNT_W-1:0]  entry_total;
    modport source (output valid, found, item_out, status, entry_total, input ready);
    modport sink   (input valid, found, item_out, status, entry_total, output ready);
endinterface

interface rhh_cfg_if;
    import rhh_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/rhh_slot_ram.sv =====
// Slot memory with registered read and per-slot occupancy bits.
module rhh_slot_ram (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rhh_pkg::t_ram_cmd         i_cmd,
    input  logic [rhh_pkg::IDX_W-1:0] i_rd_addr,
    output rhh_pkg::t_ram_rd          o_rd
);
    import rhh_pkg::*;

    t_slot            r_mem [SLOTS];
    t_slot            r_rd_slot;
    logic             r_rd_vld;
    logic [SLOTS-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd_slot <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_cmd.clr_all) begin
                r_vld <= '0;
            end else begin
                if (i_cmd.wr_en) begin
                    r_vld[i_cmd.wr_addr] <= 1'b1;
                end
                if (i_cmd.clr_en) begin
                    r_vld[i_cmd.clr_addr] <= 1'b0;
                end
            end
        end
    end

    // empty slots read with distance zero
    always_comb begin
        o_rd.vld           = r_rd_vld;
        o_rd.slot.hash     = r_rd_slot.hash;
        o_rd.slot.item     = r_rd_slot.item;
        o_rd.slot.distance = r_rd_vld ? r_rd_slot.distance : '0;
    end

endmodule

// ===== rtl/rhh_cmp.sv =====
// Shared slot compare unit: hash match, emptiness and distance ordering.
module rhh_cmp (
    input  rhh_pkg::t_slot             i_slot,
    input  logic [rhh_pkg::HASH_W-1:0] i_hash,
    input  logic [rhh_pkg::DIST_W-1:0] i_dist,
    output rhh_pkg::t_cmp              o_cmp
);
    import rhh_pkg::*;

    always_comb begin
        o_cmp.empty     = (i_slot.distance == '0);
        o_cmp.match     = (i_slot.distance != '0) && (i_slot.hash == i_hash);
        o_cmp.poorer    = (i_slot.distance < i_dist);
        o_cmp.near_home = (i_slot.distance <= DIST_W'(1));
    end

endmodule

// ===== rtl/rhh_seq.sv =====
// Probe sequencer: find, Robin Hood insert and backward-shift remove.
module rhh_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  rhh_pkg::t_func            i_req_func,
    input  logic [rhh_pkg::HASH_W-1:0] i_req_hash,
    input  logic [rhh_pkg::ITEM_W-1:0] i_req_item,
    input  logic [rhh_pkg::CNT_W-1:0] i_max_fill,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output rhh_pkg::t_result          o_res
);
    import rhh_pkg::*;

    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [ITEM_W-1:0] r_item, n_item;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_entries, n_entries;
    logic              r_found, n_found;
    logic [ITEM_W-1:0] r_item_out, n_item_out;
    logic              r_status, n_status;

    t_ram_cmd          ram_cmd;
    t_ram_rd           ram_rd;
    t_cmp              cmp;

    logic              accept;
    logic              last_step;
    logic              find_miss;
    logic              tbl_full;
    logic              shift_end;
    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  idx_dec;

    rhh_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ram_cmd),
        .i_rd_addr (n_idx),
        .o_rd      (ram_rd)
    );

    rhh_cmp u_cmp (
        .i_slot (ram_rd.slot),
        .i_hash (r_hash),
        .i_dist (r_dist),
        .o_cmp  (cmp)
    );

    assign accept    = i_req_valid && (r_state == ST_IDLE);
    assign last_step = (r_cnt == IDX_W'(SLOTS - 1));
    assign find_miss = !cmp.match && (cmp.empty || last_step);
    assign tbl_full  = (r_entries >= i_max_fill) || (r_entries >= CNT_W'(SLOTS));
    assign shift_end = cmp.near_home || last_step;
    assign idx_inc   = r_idx + 1'b1;
    assign idx_dec   = r_idx - 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_req_func == FN_CLEAR) ? ST_RESP : ST_FIND;
                end
            end
            ST_FIND: begin
                if (cmp.match) begin
                    n_state = (r_func == FN_REMOVE) ? ST_SHIFT : ST_RESP;
                end else if (find_miss) begin
                    n_state = (r_func == FN_SET && !tbl_full) ? ST_INSERT : ST_RESP;
                end
            end
            ST_INSERT: begin
                if (cmp.empty) begin
                    n_state = ST_RESP;
                end
            end
            ST_SHIFT: begin
                if (shift_end) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory commands
    always_comb begin
        n_func     = r_func;
        n_hash     = r_hash;
        n_item     = r_item;
        n_dist     = r_dist;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_entries  = r_entries;
        n_found    = r_found;
        n_item_out = r_item_out;
        n_status   = r_status;
        ram_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_func     = i_req_func;
                    n_hash     = i_req_hash & HASH_MASK;
                    n_item     = i_req_item;
                    n_idx      = i_req_hash[IDX_W-1:0];
                    n_cnt      = '0;
                    n_found    = 1'b0;
                    n_item_out = '0;
                    n_status   = 1'b0;
                    if (i_req_func == FN_CLEAR) begin
                        ram_cmd.clr_all = 1'b1;
                        n_entries       = '0;
                    end
                end
            end
            ST_FIND: begin
                if (cmp.match) begin
                    n_found    = 1'b1;
                    n_item_out = ram_rd.slot.item;
                    if (r_func == FN_SET) begin
                        ram_cmd.wr_en            = 1'b1;
                        ram_cmd.wr_addr          = r_idx;
                        ram_cmd.wr_data.distance = ram_rd.slot.distance;
                        ram_cmd.wr_data.hash     = r_hash;
                        ram_cmd.wr_data.item     = r_item;
                    end else if (r_func == FN_REMOVE) begin
                        n_idx = idx_inc;
                        n_cnt = '0;
                    end
                end else if (find_miss) begin
                    if (r_func == FN_SET) begin
                        if (tbl_full) begin
                            n_status = 1'b1;
                        end else begin
                            // second walk from home for the displacing insert
                            n_idx  = r_hash[IDX_W-1:0];
                            n_dist = DIST_W'(1);
                        end
                    end
                end else begin
                    n_idx = idx_inc;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_INSERT: begin
                if (cmp.empty || cmp.poorer) begin
                    ram_cmd.wr_en            = 1'b1;
                    ram_cmd.wr_addr          = r_idx;
                    ram_cmd.wr_data.distance = r_dist;
                    ram_cmd.wr_data.hash     = r_hash;
                    ram_cmd.wr_data.item     = r_item;
                end
                if (cmp.empty) begin
                    n_entries = r_entries + 1'b1;
                end else if (cmp.poorer) begin
                    // carry the displaced entry onward
                    n_hash = ram_rd.slot.hash;
                    n_item = ram_rd.slot.item;
                    n_dist = ram_rd.slot.distance + 1'b1;
                    n_idx  = idx_inc;
                end else begin
                    n_dist = r_dist + 1'b1;
                    n_idx  = idx_inc;
                end
            end
            ST_SHIFT: begin
                if (shift_end) begin
                    ram_cmd.clr_en   = 1'b1;
                    ram_cmd.clr_addr = idx_dec;
                    n_entries        = r_entries - CNT_W'(r_entries != '0);
                end else begin
                    ram_cmd.wr_en            = 1'b1;
                    ram_cmd.wr_addr          = idx_dec;
                    ram_cmd.wr_data.distance = ram_rd.slot.distance - 1'b1;
                    ram_cmd.wr_data.hash     = ram_rd.slot.hash;
                    ram_cmd.wr_data.item     = ram_rd.slot.item;
                    n_idx                    = idx_inc;
                    n_cnt                    = r_cnt + 1'b1;
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_entries <= '0;
        end else begin
            r_state   <= n_state;
            r_entries <= n_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_hash     <= n_hash;
        r_item     <= n_item;
        r_dist     <= n_dist;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_found    <= n_found;
        r_item_out <= n_item_out;
        r_status   <= n_status;
    end

    assign o_req_ready       = (r_state == ST_IDLE);
    assign o_res_valid       = (r_state == ST_RESP);
    assign o_res.found       = r_found;
    assign o_res.item_out    = r_item_out;
    assign o_res.status      = r_status;
    assign o_res.entry_total = r_entries;

`ifndef SYNTHESIS
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INSERT) |-> (r_entries < CNT_W'(SLOTS)))
        else $error("insert walk started with no free slot");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!ram_cmd.wr_en && !ram_cmd.clr_en))
        else $error("slot write while idle");

    a_resp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) |-> !(r_found && r_status))
        else $error("full status on a matched key");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && !i_res_ready) |=> (r_state == ST_RESP && $stable(r_entries)))
        else $error("response dropped before transfer");
`endif

endmodule

// ===== rtl/robin_hood_hash_table.sv =====
// Get/replace probe to a match, an empty slot or a full lap; insert adds a second walk from
// home to the first empty slot; remove shifts the run behind the hole back one slot and frees
// its last slot; clear goes straight to the response. One slot is probed per cycle (one RAM
// port with registered read, one shared compare unit); a new request is taken once the
// sequencer is idle, while the previous response may still sit in the output register.
// Reset: synchronous active low; all slots empty at once, count 0, max_fill 38.
module robin_hood_hash_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rhh_req_if.sink         i_req,
    rhh_rsp_if.source       o_rsp,
    rhh_cfg_if.sink         i_cfg
);
    import rhh_pkg::*;

    // fill limit register; always writable; the user must write it only while idle (not enforced)
    logic [CNT_W-1:0] r_max_fill;

    // sequencer response handshake
    logic             seq_res_valid;
    logic             seq_res_ready;
    t_result          seq_res;
    logic             res_xfer;

    // output register parts the sequencer from the response channel
    logic             r_out_vld;
    t_result          r_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fill <= MAX_FILL_RST;
        end else if (i_cfg.valid) begin
            r_max_fill <= i_cfg.data;
        end
    end

    rhh_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req_func  (t_func'(i_req.func)),
        .i_req_hash  (i_req.key_hash),
        .i_req_item  (i_req.item_value),
        .i_max_fill  (r_max_fill),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_res       (seq_res)
    );

    // take a new result when the register is empty or draining this cycle
    assign seq_res_ready = !r_out_vld || o_rsp.ready;
    assign res_xfer      = seq_res_valid && seq_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_xfer) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_xfer) begin
            r_out <= seq_res;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.item_out    = r_out.item_out;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.entry_total = r_out.entry_total;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the Robin Hood hash table: directed and random ops against a predictor.
`timescale 1ns / 100ps

module tb;
    import rhh_pkg::*;

    // Run limits. A worst-case op walks the table up to twice. Even with every stall and gap,
    // ~900 ops stay well inside this bound.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 200;  // quiet time after the last response
    localparam int POOL        = 16;   // keys reused within a random phase

    logic i_clk;
    logic i_rst_n;

    rhh_req_if req_ch ();
    rhh_rsp_if rsp_ch ();
    rhh_cfg_if cfg_ch ();

    robin_hood_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Table predictor: its own copy of the slots, the count and the limit.
    // ------------------------------------------------------------------
    logic [HASH_W-1:0] tbl_hash [SLOTS];
    logic [ITEM_W-1:0] tbl_item [SLOTS];
    int                tbl_dist [SLOTS];  // 0 = empty, 1 = home slot
    int unsigned       tbl_count;
    logic [CNT_W-1:0]  fill_limit;

    t_result owed_results[$];  // predicted responses, oldest first
    int      mismatch_count;
    int      cycle_count;

    // Stimulus knobs; the response-side ones are shared with the drain process.
    bit send_gaps;
    bit rsp_gaps;
    int drain_hold;  // one-shot long hold-off of the response side, in cycles

    logic [HASH_W-1:0] key_pool [POOL];

    function automatic bit table_find(input logic [HASH_W-1:0] h, output int pos);
        int i;
        i   = int'(h[IDX_W-1:0]);
        pos = 0;
        // Walk is bounded: a miss on a full table stops after one lap.
        for (int n = 0; n < SLOTS; n++) begin
            if (tbl_dist[i] == 0)
                return 1'b0;
            if (tbl_hash[i] == h) begin
                pos = i;
                return 1'b1;
            end
            i = (i + 1) % SLOTS;
        end
        return 1'b0;
    endfunction

    // Only called with at least one free slot.
    function automatic void table_insert(input logic [HASH_W-1:0] h,
                                         input logic [ITEM_W-1:0] v);
        int                i;
        int                d;
        int                td;
        logic [HASH_W-1:0] th;
        logic [ITEM_W-1:0] tv;
        i = int'(h[IDX_W-1:0]);
        d = 1;
        for (int n = 0; n < SLOTS; n++) begin
            if (tbl_dist[i] == 0) begin
                tbl_hash[i] = h;
                tbl_item[i] = v;
                tbl_dist[i] = d;
                tbl_count++;
                return;
            end
            // Robin Hood swap: take the slot from an entry closer to its home.
            if (tbl_dist[i] < d) begin
                th = tbl_hash[i];
                tv = tbl_item[i];
                td = tbl_dist[i];
                tbl_hash[i] = h;
                tbl_item[i] = v;
                tbl_dist[i] = d;
                h = th;
                v = tv;
                d = td;
            end
            i = (i + 1) % SLOTS;
            d++;
        end
    endfunction

    // Backward-shift delete: pull the run behind the hole one slot toward home.
    function automatic void table_remove(input int p);
        int nx;
        for (int n = 0; n + 1 < SLOTS; n++) begin
            nx = (p + 1) % SLOTS;
            if (tbl_dist[nx] <= 1)
                break;
            tbl_hash[p] = tbl_hash[nx];
            tbl_item[p] = tbl_item[nx];
            tbl_dist[p] = tbl_dist[nx] - 1;
            p = nx;
        end
        tbl_dist[p] = 0;
        if (tbl_count > 0)
            tbl_count--;
    endfunction

    function automatic t_result table_apply(input t_func f, input logic [HASH_W-1:0] h,
                                            input logic [ITEM_W-1:0] v);
        t_result res;
        int      pos;
        bit      hit;
        res = '0;
        pos = 0;
        hit = 1'b0;
        if (f != FN_CLEAR)
            hit = table_find(h, pos);
        case (f)
            FN_GET: begin
                if (hit) begin
                    res.found    = 1'b1;
                    res.item_out = tbl_item[pos];
                end
            end
            FN_SET: begin
                if (hit) begin
                    // Replace goes through even at the fill limit.
                    res.found     = 1'b1;
                    res.item_out  = tbl_item[pos];
                    tbl_item[pos] = v;
                end else if (tbl_count >= fill_limit || tbl_count >= SLOTS) begin
                    res.status = 1'b1;
                end else begin
                    table_insert(h, v);
                end
            end
            FN_REMOVE: begin
                if (hit) begin
                    res.found    = 1'b1;
                    res.item_out = tbl_item[pos];
                    table_remove(pos);
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++)
                    tbl_dist[i] = 0;
                tbl_count = 0;
            end
        endcase
        res.entry_total = tbl_count[CNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sampled at the rising edge, before the block's updates land.
    // Response check runs ahead of the request prediction of the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (owed_results.size() == 0) begin
                    $error("response transfer with nothing expected");
                    mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (rsp_ch.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
                        mismatch_count++;
                    end
                    if (rsp_ch.item_out !== want.item_out) begin
                        $error("item_out: expected %h, got %h", want.item_out,
                               rsp_ch.item_out);
                        mismatch_count++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatch_count++;
                    end
                    if (rsp_ch.entry_total !== want.entry_total) begin
                        $error("entry_total: expected %0d, got %0d", want.entry_total,
                               rsp_ch.entry_total);
                        mismatch_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                owed_results.push_back(table_apply(t_func'(req_ch.func), req_ch.key_hash,
                                                   req_ch.item_value));
            if (cfg_ch.valid && cfg_ch.ready)
                fill_limit = cfg_ch.data;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Response side: short random stalls, plus a long hold when a test asks for one.
    initial begin : drain
        int low_run;
        low_run      = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (drain_hold > 0) begin
                low_run    = drain_hold;
                drain_hold = 0;
            end else if (low_run == 0 && rsp_gaps && $urandom_range(0, 3) == 0) begin
                low_run = $urandom_range(1, 3);
            end
            if (low_run > 0) begin
                rsp_ch.ready <= 1'b0;
                low_run--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All drive at the falling edge.
    // ------------------------------------------------------------------

    // Valid is left high on return: the next call either reloads it or drops it.
    task automatic send_op(input t_func f, input logic [HASH_W-1:0] h,
                           input logic [ITEM_W-1:0] v);
        int gap;
        gap = 0;
        if (send_gaps && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.key_hash   <= h;
        req_ch.item_value <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Config writes only with the block idle.
    task automatic write_fill_limit(input logic [CNT_W-1:0] lim);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= lim;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [HASH_W-1:0] rand_hash();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[HASH_W-1:0];
    endfunction

    // Random upper bits over a chosen home slot.
    function automatic logic [HASH_W-1:0] home_key(input logic [HASH_W-1:0] upper,
                                                   input int home);
        logic [HASH_W-1:0] k;
        k = upper << IDX_W;
        k[IDX_W-1:0] = home[IDX_W-1:0];
        return k;
    endfunction

    // Pool keys share a narrow band of homes so probe runs collide and wrap.
    task automatic refill_pool(input int spread);
        int base;
        base = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < POOL; k++)
            key_pool[k] = home_key(rand_hash(), (base + $urandom_range(0, spread)) % SLOTS);
    endtask

    function automatic logic [HASH_W-1:0] pick_key();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 60)
            return key_pool[$urandom_range(0, POOL - 1)];
        if (r < 80 && tbl_count > 0) begin
            // Live entry straight from the predictor.
            s = $urandom_range(0, SLOTS - 1);
            while (tbl_dist[s] == 0)
                s = (s + 1) % SLOTS;
            return tbl_hash[s];
        end
        return rand_hash();
    endfunction

    function automatic t_func pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return FN_SET;
        if (r < 75) return FN_GET;
        if (r < 97) return FN_REMOVE;
        return FN_CLEAR;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every op once, extreme keys and values, replace, miss, clear.
    task automatic test_basic_ops();
        send_op(FN_GET, '0, '0);                          // miss on empty table
        send_op(FN_SET, '0, '0);
        send_op(FN_SET, HASH_MASK, 32'hFFFF_FFFF);        // home is the last slot
        send_op(FN_SET, 48'h0000_0000_0040, 32'h1234_5678);
        send_op(FN_GET, HASH_MASK, 32'hFFFF_FFFF);
        send_op(FN_SET, '0, 32'hA5A5_5A5A);               // replace
        send_op(FN_GET, '0, '0);
        send_op(FN_REMOVE, 48'h0000_0000_0040, '0);
        send_op(FN_REMOVE, 48'h0000_0000_0040, '0);       // miss
        send_op(FN_SET, 48'h5555_5555_5555, 32'h5555_5555);
        send_op(FN_GET, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        send_op(FN_CLEAR, HASH_MASK, 32'hFFFF_FFFF);
        send_op(FN_GET, HASH_MASK, '0);                   // gone after clear
        wait_drained();
    endtask

    // Collisions around the wrap point: displacement on insert, backward shift on remove.
    task automatic test_probe_chain();
        send_op(FN_SET, home_key(48'd1, 62), 32'h0000_0001);
        send_op(FN_SET, home_key(48'd2, 62), 32'h0000_0002);
        send_op(FN_SET, home_key(48'd3, 62), 32'h0000_0003);  // wraps to slot 0
        send_op(FN_SET, home_key(48'd1, 63), 32'h0000_0004);
        send_op(FN_SET, home_key(48'd1, 0),  32'h0000_0005);
        send_op(FN_SET, home_key(48'd4, 62), 32'h0000_0006);  // displaces a richer entry
        send_op(FN_REMOVE, home_key(48'd1, 62), '0);          // shifts the whole run back
        send_op(FN_GET, home_key(48'd4, 62), '0);
        send_op(FN_GET, home_key(48'd1, 0), '0);
        send_op(FN_GET, home_key(48'd5, 63), '0);             // miss deep in the run
        send_op(FN_CLEAR, '0, '0);
        wait_drained();
    endtask

    // Fill limit: refusal, replace at the limit, zero limit, limit lowered under count.
    task automatic test_fill_limit();
        write_fill_limit(7'd3);
        send_op(FN_SET, 48'h0000_0000_0011, 32'h11);
        send_op(FN_SET, 48'h0000_0000_0051, 32'h22);
        send_op(FN_SET, 48'h0000_0000_0012, 32'h33);
        send_op(FN_SET, 48'h0000_0000_0013, 32'h44);      // refused
        send_op(FN_SET, 48'h0000_0000_0051, 32'h55);      // replace still allowed
        wait_drained();
        write_fill_limit(7'd0);
        send_op(FN_SET, 48'h0000_0000_0014, 32'h66);      // refused
        wait_drained();
        write_fill_limit(7'd1);                           // below the current count
        send_op(FN_SET, 48'h0000_0000_0015, 32'h77);
        send_op(FN_REMOVE, 48'h0000_0000_0011, '0);
        send_op(FN_REMOVE, 48'h0000_0000_0051, '0);
        send_op(FN_SET, 48'h0000_0000_0016, 32'h88);      // count 1, still refused
        send_op(FN_REMOVE, 48'h0000_0000_0012, '0);
        send_op(FN_SET, 48'h0000_0000_0016, 32'h99);      // accepted
        send_op(FN_CLEAR, '0, '0);
        wait_drained();
    endtask

    task automatic test_random_mix(input int n, input int spread);
        refill_pool(spread);
        repeat (n) begin
            send_op(pick_func(), pick_key(), $urandom());
            if ($urandom_range(0, 49) == 0)
                refill_pool(spread);
        end
        wait_drained();
    endtask

    // Every slot taken: refusal at the slot bound and one-lap misses.
    task automatic test_full_table();
        int base;
        write_fill_limit(7'd64);
        send_op(FN_CLEAR, '0, '0);
        base = $urandom_range(0, SLOTS - 1);
        while (tbl_count < SLOTS)
            send_op(FN_SET, home_key(rand_hash(), (base + $urandom_range(0, 20)) % SLOTS),
                    $urandom());
        send_op(FN_SET, rand_hash(), $urandom());         // refused, table full
        repeat (20) send_op(FN_GET, rand_hash(), $urandom());
        repeat (20) send_op(FN_GET, tbl_hash[$urandom_range(0, SLOTS - 1)], $urandom());
        repeat (5) send_op(FN_REMOVE, rand_hash(), $urandom());
        wait_drained();
        test_random_mix(60, 20);
    endtask

    // Long receiver hold while requests keep coming, then paused bursts.
    task automatic test_backpressure();
        refill_pool(6);
        drain_hold = 250;
        repeat (12) send_op(pick_func(), pick_key(), $urandom());
        wait_drained();
        repeat (10) begin
            repeat ($urandom_range(1, 4)) send_op(pick_func(), pick_key(), $urandom());
            wait_drained();
        end
    endtask

    task automatic end_run();
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_hash[i] = '0;
            tbl_item[i] = '0;
            tbl_dist[i] = 0;
        end
        tbl_count      = 0;
        fill_limit     = MAX_FILL_RST;
        mismatch_count = 0;
        cycle_count    = 0;
        drain_hold     = 0;
        send_gaps      = 1'b1;
        rsp_gaps       = 1'b1;

        req_ch.valid      = 1'b0;
        req_ch.func       = FN_GET;
        req_ch.key_hash   = '0;
        req_ch.item_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        i_rst_n           = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_ops();
        test_probe_chain();
        test_fill_limit();

        write_fill_limit(MAX_FILL_RST);
        test_random_mix(250, 7);
        test_full_table();
        write_fill_limit(7'd127);      // above the slot count: slots bound the fill
        test_random_mix(100, 3);
        write_fill_limit(7'd2);
        test_random_mix(60, 15);
        test_backpressure();

        // Last stretch at full rate on both sides.
        write_fill_limit(MAX_FILL_RST);
        send_gaps = 1'b0;
        rsp_gaps  = 1'b0;
        test_random_mix(200, 5);

        end_run();
    end

endmodule
